>>> src/i2crs_pkg.sv
package i2crs_pkg;

    // Event kinds carried by an input beat
    typedef enum logic [2:0] {
        KIND_CTRL_EVENT = 3'd0,
        KIND_CTRL_ERROR = 3'd1,
        KIND_DMA_STATUS = 3'd2,
        KIND_TIMEOUT    = 3'd3,
        KIND_START      = 3'd4
    } t_kind;

    // Transfer phase, reported as bus_state
    typedef enum logic [2:0] {
        PH_IDLE        = 3'd0,
        PH_SEND_WADDR  = 3'd1,
        PH_SEND_REG    = 3'd2,
        PH_RESTART     = 3'd3,
        PH_SEND_RADDR  = 3'd4,
        PH_RECEIVING   = 3'd5,
        PH_UNAVAILABLE = 3'd6
    } t_phase;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_DMA       = 3'd1,
        ERR_NACK      = 3'd2,
        ERR_ARB_LOST  = 3'd3,
        ERR_BUS       = 3'd4
    } t_err;

    // Configuration register indexes
    localparam logic [1:0] CFG_TARGET_ADDRESS   = 2'd0;
    localparam logic [1:0] CFG_TARGET_REGISTER  = 2'd1;
    localparam logic [1:0] CFG_RETRY_LIMIT      = 2'd2;
    localparam logic [1:0] CFG_DMA_STREAM_INDEX = 2'd3;

    localparam logic [7:0] RETRY_LIMIT_RESET = 8'd3;

    // DMA control codes
    localparam logic [1:0] DMA_CTL_NONE    = 2'd0;
    localparam logic [1:0] DMA_CTL_ENABLE  = 2'd1;
    localparam logic [1:0] DMA_CTL_DISABLE = 2'd2;

    // Controller status bits
    localparam int SR_START_SENT = 0;
    localparam int SR_ADDR_DONE  = 1;
    localparam int SR_BYTE_DONE  = 2;
    localparam int SR_TX_EMPTY   = 7;
    localparam int SR_BUS_ERR    = 8;
    localparam int SR_ARB_LOST   = 9;
    localparam int SR_NACK       = 10;

    // Error clear mask bits
    localparam logic [2:0] ECLR_BUS  = 3'b001;
    localparam logic [2:0] ECLR_ARB  = 3'b010;
    localparam logic [2:0] ECLR_NACK = 3'b100;

    // DMA flag group layout
    localparam logic [4:0] DMA_TE_OFS     = 5'd3;
    localparam logic [4:0] DMA_TC_OFS     = 5'd5;
    localparam logic [31:0] DMA_GROUP_ALL = 32'h0000_003D;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] ctrl_status;
        logic [31:0] dma_status;
        logic        recovery_ok;
    } t_in_item;

    typedef struct packed {
        logic        data_write;
        logic [7:0]  data_byte;
        logic        start_request;
        logic        stop_request;
        logic [1:0]  dma_control;
        logic [31:0] dma_clear_mask;
        logic        status2_read;
        logic        dma_mode_switch;
        logic        timer_stop;
        logic [2:0]  error_clear_mask;
        logic [2:0]  error_code;
        logic [2:0]  bus_state;
    } t_out_item;

    typedef struct packed {
        logic [6:0] target_address;
        logic [7:0] target_register;
        logic [7:0] retry_limit;
        logic [2:0] dma_stream_index;
    } t_cfg;

    typedef struct packed {
        t_phase     phase;
        t_err       error_kind;
        logic [7:0] retries_used;
    } t_seq_state;

    // Base bit of a stream's flag group inside the DMA status word
    function automatic logic [4:0] flag_base(input logic [1:0] stream);
        logic [4:0] base;
        unique case (stream)
            2'd0: base = 5'd0;
            2'd1: base = 5'd6;
            2'd2: base = 5'd16;
            2'd3: base = 5'd22;
            default: base = 5'd0;
        endcase
        return base;
    endfunction

endpackage

>>> src/i2crs_cfg_regs.sv
module i2crs_cfg_regs
    import i2crs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_wdata,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_address   <= '0;
            r_cfg.target_register  <= '0;
            r_cfg.retry_limit      <= RETRY_LIMIT_RESET;
            r_cfg.dma_stream_index <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TARGET_ADDRESS:   r_cfg.target_address   <= i_cfg_wdata[6:0];
                CFG_TARGET_REGISTER:  r_cfg.target_register  <= i_cfg_wdata;
                CFG_RETRY_LIMIT:      r_cfg.retry_limit      <= i_cfg_wdata;
                CFG_DMA_STREAM_INDEX: r_cfg.dma_stream_index <= i_cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> src/i2crs_step.sv
module i2crs_step
    import i2crs_pkg::*;
(
    input  t_in_item   i_item,
    input  t_cfg       i_cfg,
    input  t_seq_state i_state,
    output t_seq_state o_state,
    output t_out_item  o_result
);

    logic [4:0]  base;
    logic [31:0] te_bit;
    logic [31:0] tc_bit;
    logic [15:0] sr;
    t_seq_state  nxt;
    t_out_item   res;

    assign sr     = i_item.ctrl_status;
    assign base   = flag_base(i_cfg.dma_stream_index[1:0]);
    assign te_bit = 32'd1 << (base + DMA_TE_OFS);
    assign tc_bit = 32'd1 << (base + DMA_TC_OFS);

    always_comb begin
        nxt = i_state;
        res = '0;
        unique case (i_item.kind)
            KIND_CTRL_EVENT: begin
                unique case (i_state.phase)
                    PH_SEND_WADDR: begin
                        if (sr[SR_START_SENT]) begin
                            res.data_write = 1'b1;
                            res.data_byte  = {i_cfg.target_address, 1'b0};
                            nxt.phase      = PH_SEND_REG;
                        end
                    end
                    PH_SEND_REG: begin
                        res.status2_read = sr[SR_ADDR_DONE];
                        if (sr[SR_TX_EMPTY]) begin
                            res.data_write = 1'b1;
                            res.data_byte  = i_cfg.target_register;
                            nxt.phase      = PH_RESTART;
                        end
                    end
                    PH_RESTART: begin
                        if (sr[SR_BYTE_DONE]) begin
                            res.start_request = 1'b1;
                            nxt.phase         = PH_SEND_RADDR;
                        end
                    end
                    PH_SEND_RADDR: begin
                        if (sr[SR_START_SENT]) begin
                            res.dma_mode_switch = 1'b1;
                            res.data_write      = 1'b1;
                            res.data_byte       = {i_cfg.target_address, 1'b1};
                        end
                        if (sr[SR_ADDR_DONE]) begin
                            nxt.phase        = PH_RECEIVING;
                            res.dma_control  = DMA_CTL_ENABLE;
                            res.status2_read = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            KIND_CTRL_ERROR: begin
                res.dma_control = DMA_CTL_DISABLE;
                // nack, then arbitration lost, then bus error: last code wins
                if (sr[SR_NACK]) begin
                    res.error_clear_mask = res.error_clear_mask | ECLR_NACK;
                    res.stop_request     = 1'b1;
                    nxt.error_kind       = ERR_NACK;
                end
                if (sr[SR_ARB_LOST]) begin
                    res.error_clear_mask = res.error_clear_mask | ECLR_ARB;
                    res.stop_request     = 1'b1;
                    nxt.error_kind       = ERR_ARB_LOST;
                end
                if (sr[SR_BUS_ERR]) begin
                    res.error_clear_mask = res.error_clear_mask | ECLR_BUS;
                    res.stop_request     = 1'b1;
                    if (i_state.retries_used < i_cfg.retry_limit) begin
                        nxt.retries_used  = i_state.retries_used + 8'd1;
                        res.start_request = 1'b1;
                        nxt.phase         = PH_SEND_WADDR;
                    end else begin
                        nxt.error_kind = ERR_BUS;
                    end
                end
            end
            KIND_DMA_STATUS: begin
                res.dma_control = DMA_CTL_DISABLE;
                if ((i_item.dma_status & te_bit) != '0) begin
                    res.dma_clear_mask = DMA_GROUP_ALL << base;
                    nxt.error_kind     = ERR_DMA;
                end else if ((i_item.dma_status & tc_bit) != '0) begin
                    res.dma_clear_mask = tc_bit;
                    if (i_state.phase == PH_RECEIVING) begin
                        res.timer_stop   = 1'b1;
                        res.stop_request = 1'b1;
                        nxt.phase        = PH_IDLE;
                    end
                end
            end
            KIND_TIMEOUT: begin
                res.timer_stop = 1'b1;
                if (i_state.error_kind == ERR_NONE && !i_item.recovery_ok) begin
                    nxt.phase = PH_UNAVAILABLE;
                end else begin
                    nxt.phase = PH_IDLE;
                end
            end
            KIND_START: begin
                nxt.retries_used  = '0;
                nxt.error_kind    = ERR_NONE;
                res.start_request = 1'b1;
                nxt.phase         = PH_SEND_WADDR;
            end
            default: ;
        endcase
        res.error_code = nxt.error_kind;
        res.bus_state  = nxt.phase;
    end

    assign o_state  = nxt;
    assign o_result = res;

endmodule

>>> src/i2c_register_read_sequencer.sv
// Register-read sequencer for an I2C master. Start it with a start-request beat;
// it then walks write address, register byte, repeated start and read address,
// and hands the data phase to the receive DMA stream selected by
// dma_stream_index. Every accepted input beat gives exactly one result beat
// with the actions to take plus the error code and bus state after the event.
// An input beat is registered in the input register, decoded by combinational
// logic and then captured in the result register. A new beat is taken every
// cycle while the input side is not held; the only thing that holds it is
// a full result register that the consumer stalls. Write configuration only
// while no beat is in flight.
module i2c_register_read_sequencer
    import i2crs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input events
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in_data,
    // result beats
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out_data,
    // configuration writes
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_wdata
);

    t_cfg       cfg;
    t_seq_state r_state;
    t_seq_state n_state;
    t_out_item  step_result;

    logic       r_in_vld;
    t_in_item   r_in_item;
    logic       r_out_vld;
    t_out_item  r_out_item;

    logic       out_free;
    logic       advance;
    logic       in_take;

    i2crs_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    i2crs_step u_step (
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (step_result)
    );

    // Result register is free when empty or being taken this cycle
    assign out_free   = !r_out_vld || !i_out_stall;
    // Move the registered event into the result register
    assign advance    = r_in_vld && out_free;
    // Hold the input side only while the event register cannot drain
    assign o_in_stall = r_in_vld && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!r_in_vld || advance) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item <= i_in_data;
        end
    end

    // Sequencer state: commit only when the event's result is captured
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase        <= PH_IDLE;
            r_state.error_kind   <= ERR_NONE;
            r_state.retries_used <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= step_result;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_item;

endmodule
